FILE: rtl/mssbt_pkg.sv
// Shared types, codes and constants for the motor speed supervisor and brake timer.
`default_nettype none

package mssbt_pkg;

  // Tempo line end points and fixed command values
  localparam logic [7:0]  TEMPO_LO      = 8'd32;
  localparam logic [6:0]  TEMPO_SPAN    = 7'd112;   // 144 - 32
  localparam logic [6:0]  PERCENT       = 7'd100;
  localparam logic [31:0] BRAKE_SPEED   = 32'd1000;
  localparam logic [31:0] BRAKE_HOLD_MS = 32'd2000;

  // Status codes on the input word
  localparam logic [1:0] LIMIT_END  = 2'd2;
  localparam logic [2:0] POWER_GOOD = 3'd3;

  // Move permission codes
  localparam logic [1:0] PERM_STOP  = 2'd0;
  localparam logic [1:0] PERM_RUN   = 2'd1;
  localparam logic [1:0] PERM_BRAKE = 2'd2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMPO_SPEED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMPO_SPEED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR_RATIO_PERCENT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_SCALE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_VELOCITY     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_DELAY_MS     = 3'd5;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic [7:0]         tempo;
    logic [1:0]         limit_switch_state;
    logic               init_done;
    logic [2:0]         power_state;
    logic signed [23:0] measured_velocity;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  move_permission;
    logic        drive_enable;
    logic [31:0] speed_command;
    logic        brake_active;
  } out_word_t;

  // Status of one speed limit lane
  typedef struct packed {
    logic        busy;
    logic [15:0] limit;
  } lane_stat_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_LIMITS,
    CS_MAP,
    CS_HOLD
  } ctrl_state_e;

  typedef enum logic [1:0] {
    LS_IDLE,
    LS_MUL,
    LS_DIV,
    LS_SCALE
  } lane_state_e;

  typedef enum logic [1:0] {
    MP_IDLE,
    MP_MUL,
    MP_DIV,
    MP_FIN
  } map_state_e;

endpackage

`default_nettype wire

FILE: rtl/mssbt_limit.sv
// Bit-serial speed limit lane: ((base * ratio) / 100 mod 2^16) * scale mod 2^16.
`default_nettype none

module mssbt_limit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [15:0]        base_i,
  input  wire logic [15:0]        ratio_i,
  input  wire logic [15:0]        scale_i,
  output mssbt_pkg::lane_stat_t   stat_o
);

  localparam logic [4:0] MUL_LAST = 5'd15;
  localparam logic [4:0] DIV_LAST = 5'd31;

  mssbt_pkg::lane_state_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] limit_q, limit_d;
  logic [15:0] mplr_q, mplr_d;
  logic [31:0] mcand_q, mcand_d;
  logic [31:0] acc_q, acc_d;
  logic [6:0]  rem_q, rem_d;
  logic [15:0] scale_q, scale_d;

  logic [31:0] acc_add;
  logic [7:0]  rsh;
  logic [7:0]  rsh_sub;
  logic        ge;
  logic [31:0] quo;

  // shared datapath pieces
  assign acc_add = acc_q + (mplr_q[0] ? mcand_q : 32'd0);
  assign rsh     = {rem_q, acc_q[31]};
  assign rsh_sub = rsh - {1'b0, mssbt_pkg::PERCENT};
  assign ge      = (rsh >= {1'b0, mssbt_pkg::PERCENT});
  assign quo     = {acc_q[30:0], ge};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    limit_d = limit_q;
    mplr_d  = mplr_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    scale_d = scale_q;
    unique case (state_q)
      mssbt_pkg::LS_IDLE: begin
        if (start_i) begin
          mplr_d  = base_i;
          mcand_d = {16'd0, ratio_i};
          acc_d   = 32'd0;
          scale_d = scale_i;
          cnt_d   = 5'd0;
          state_d = mssbt_pkg::LS_MUL;
        end
      end
      mssbt_pkg::LS_MUL: begin
        acc_d   = acc_add;
        mcand_d = {mcand_q[30:0], 1'b0};
        mplr_d  = {1'b0, mplr_q[15:1]};
        cnt_d   = cnt_q + 5'd1;
        if (cnt_q == MUL_LAST) begin
          cnt_d   = 5'd0;
          rem_d   = 7'd0;
          state_d = mssbt_pkg::LS_DIV;
        end
      end
      mssbt_pkg::LS_DIV: begin
        rem_d = ge ? rsh_sub[6:0] : rsh[6:0];
        acc_d = quo;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == DIV_LAST) begin
          // quotient done; only its low half feeds the scale multiply
          mplr_d  = quo[15:0];
          mcand_d = {16'd0, scale_q};
          acc_d   = 32'd0;
          cnt_d   = 5'd0;
          state_d = mssbt_pkg::LS_SCALE;
        end
      end
      mssbt_pkg::LS_SCALE: begin
        acc_d   = acc_add;
        mcand_d = {mcand_q[30:0], 1'b0};
        mplr_d  = {1'b0, mplr_q[15:1]};
        cnt_d   = cnt_q + 5'd1;
        if (cnt_q == MUL_LAST) begin
          limit_d = acc_add[15:0];
          cnt_d   = 5'd0;
          state_d = mssbt_pkg::LS_IDLE;
        end
      end
      default: state_d = mssbt_pkg::LS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mssbt_pkg::LS_IDLE;
      cnt_q   <= 5'd0;
      limit_q <= 16'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      limit_q <= limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mplr_q  <= mplr_d;
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    scale_q <= scale_d;
  end

  assign stat_o.busy  = (state_q != mssbt_pkg::LS_IDLE);
  assign stat_o.limit = limit_q;

endmodule

`default_nettype wire

FILE: rtl/mssbt_map.sv
// Bit-serial tempo map: (tempo - 32) * (hi - lo) / 112 + lo, truncating toward zero.
`default_nettype none

module mssbt_map (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [7:0]  tempo_i,
  input  wire logic [15:0] lo_i,
  input  wire logic [15:0] hi_i,
  output logic             done_o,
  output logic [31:0]      speed_o
);

  localparam logic [4:0] MUL_LAST = 5'd7;
  localparam logic [4:0] DIV_LAST = 5'd23;

  mssbt_pkg::map_state_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [7:0]  mplr_q, mplr_d;
  logic [23:0] mcand_q, mcand_d;
  logic [23:0] acc_q, acc_d;
  logic [6:0]  rem_q, rem_d;
  logic        neg_q, neg_d;
  logic [15:0] lo_q, lo_d;

  logic [8:0]  a9, abs_a9;
  logic [16:0] d17, abs_d17;
  logic [23:0] acc_add;
  logic [7:0]  rsh, rsh_sub;
  logic        ge;
  logic [31:0] qx;

  // signed operands, taken apart into sign and magnitude
  assign a9      = {1'b0, tempo_i} - {1'b0, mssbt_pkg::TEMPO_LO};
  assign d17     = {1'b0, hi_i} - {1'b0, lo_i};
  assign abs_a9  = a9[8] ? (~a9 + 9'd1) : a9;
  assign abs_d17 = d17[16] ? (~d17 + 17'd1) : d17;

  assign acc_add = acc_q + (mplr_q[0] ? mcand_q : 24'd0);
  assign rsh     = {rem_q, acc_q[23]};
  assign rsh_sub = rsh - {1'b0, mssbt_pkg::TEMPO_SPAN};
  assign ge      = (rsh >= {1'b0, mssbt_pkg::TEMPO_SPAN});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mplr_d  = mplr_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    lo_d    = lo_q;
    unique case (state_q)
      mssbt_pkg::MP_IDLE: begin
        if (start_i) begin
          mplr_d  = abs_a9[7:0];
          mcand_d = {8'd0, abs_d17[15:0]};
          acc_d   = 24'd0;
          neg_d   = a9[8] ^ d17[16];
          lo_d    = lo_i;
          cnt_d   = 5'd0;
          state_d = mssbt_pkg::MP_MUL;
        end
      end
      mssbt_pkg::MP_MUL: begin
        acc_d   = acc_add;
        mcand_d = {mcand_q[22:0], 1'b0};
        mplr_d  = {1'b0, mplr_q[7:1]};
        cnt_d   = cnt_q + 5'd1;
        if (cnt_q == MUL_LAST) begin
          cnt_d   = 5'd0;
          rem_d   = 7'd0;
          state_d = mssbt_pkg::MP_DIV;
        end
      end
      mssbt_pkg::MP_DIV: begin
        rem_d = ge ? rsh_sub[6:0] : rsh[6:0];
        acc_d = {acc_q[22:0], ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == DIV_LAST) begin
          cnt_d   = 5'd0;
          state_d = mssbt_pkg::MP_FIN;
        end
      end
      mssbt_pkg::MP_FIN: begin
        state_d = mssbt_pkg::MP_IDLE;
      end
      default: state_d = mssbt_pkg::MP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mssbt_pkg::MP_IDLE;
      cnt_q   <= 5'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mplr_q  <= mplr_d;
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    neg_q   <= neg_d;
    lo_q    <= lo_d;
  end

  // negate through inverted operand plus carry-in, then add lo
  assign qx      = {8'd0, acc_q};
  assign speed_o = (neg_q ? ~qx : qx) + {16'd0, lo_q} + {31'd0, neg_q};
  assign done_o  = (state_q == mssbt_pkg::MP_FIN);

endmodule

`default_nettype wire

FILE: rtl/mssbt_brake.sv
// Overspeed brake timer: slow-time stamp, brake start and 2000 ms brake hold.
`default_nettype none

module mssbt_brake (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               tick_i,
  input  wire logic [31:0]        now_i,
  input  wire logic signed [23:0] vel_i,
  input  wire logic [22:0]        brake_velocity_i,
  input  wire logic [31:0]        brake_delay_i,
  output logic                    braking_o
);

  logic        braking_q, braking_d;
  logic [31:0] start_q, start_d;
  logic [31:0] last_slow_q, last_slow_d;

  logic [23:0] mag;
  logic        slow;
  logic [31:0] fast_time;
  logic [31:0] hold_time;
  logic        begin_brake;
  logic        end_brake;

  // |v| fits 24 bits unsigned, the most negative value included
  assign mag       = vel_i[23] ? (~vel_i + 24'd1) : vel_i;
  assign slow      = (mag < {1'b0, brake_velocity_i});
  assign fast_time = now_i - last_slow_q;
  assign hold_time = now_i - start_q;

  // a slow tick leaves zero overspeed time, so it can never start the brake
  assign begin_brake = !braking_q && !slow && (fast_time > brake_delay_i);
  assign end_brake   = braking_q && (hold_time > mssbt_pkg::BRAKE_HOLD_MS);

  // start and end exclude each other: one needs the brake off, the other on
  always_comb begin
    braking_d   = braking_q;
    start_d     = start_q;
    last_slow_d = last_slow_q;
    if (tick_i) begin
      if (slow) begin
        last_slow_d = now_i;
      end
      if (begin_brake) begin
        braking_d = 1'b1;
        start_d   = now_i;
      end else if (end_brake) begin
        braking_d = 1'b0;
        start_d   = 32'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      braking_q   <= 1'b0;
      start_q     <= 32'd0;
      last_slow_q <= 32'd0;
    end else begin
      braking_q   <= braking_d;
      start_q     <= start_d;
      last_slow_q <= last_slow_d;
    end
  end

  assign braking_o = braking_q;

endmodule

`default_nettype wire

FILE: rtl/motor_speed_supervisor_brake_timer_core.sv
// Top level of the motor speed supervisor with overspeed brake timer.
`default_nettype none

// One input word per control tick gives one output word. A tick whose
// permission is stop or braking run skips the tempo map and goes straight
// to the output hold state. A tick with permission run goes through the
// bit-serial tempo map (shift-add multiply, restoring divide by 112, then
// sign and offset). The two speed limits depend only on registers 0..3 and
// are recomputed by two parallel bit-serial lanes after any write to those
// registers (multiply, divide by 100, scale multiply), during which
// in_stall_o is high. The output register lets the next word be accepted
// while a result still waits. The user must write configuration through
// cfg_we_i / cfg_idx_i / cfg_wdata_i only while no tick is in flight; the
// block itself does not enforce this. Unknown indexes are ignored.

module motor_speed_supervisor_brake_timer_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire mssbt_pkg::in_word_t                   in_word_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output mssbt_pkg::out_word_t                       out_word_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [mssbt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [mssbt_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] min_speed_q, max_speed_q, ratio_q, scale_q;
  logic [22:0] brake_vel_q;
  logic [31:0] brake_delay_q;
  logic        limit_cfg_wr;   // write that invalidates the speed limits

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q   <= 16'd0;
      max_speed_q   <= 16'd0;
      ratio_q       <= 16'd100;
      scale_q       <= 16'd1;
      brake_vel_q   <= 23'd0;
      brake_delay_q <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mssbt_pkg::CFG_MIN_TEMPO_SPEED:    min_speed_q   <= cfg_wdata_i[15:0];
        mssbt_pkg::CFG_MAX_TEMPO_SPEED:    max_speed_q   <= cfg_wdata_i[15:0];
        mssbt_pkg::CFG_GEAR_RATIO_PERCENT: ratio_q       <= cfg_wdata_i[15:0];
        mssbt_pkg::CFG_VELOCITY_SCALE:     scale_q       <= cfg_wdata_i[15:0];
        mssbt_pkg::CFG_BRAKE_VELOCITY:     brake_vel_q   <= cfg_wdata_i[22:0];
        mssbt_pkg::CFG_BRAKE_DELAY_MS:     brake_delay_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign limit_cfg_wr = cfg_we_i && ((cfg_idx_i == mssbt_pkg::CFG_MIN_TEMPO_SPEED) ||
                                     (cfg_idx_i == mssbt_pkg::CFG_MAX_TEMPO_SPEED) ||
                                     (cfg_idx_i == mssbt_pkg::CFG_GEAR_RATIO_PERCENT) ||
                                     (cfg_idx_i == mssbt_pkg::CFG_VELOCITY_SCALE));

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------
  mssbt_pkg::ctrl_state_e state_q, state_d;
  logic        dirty_q, dirty_d;        // limits stale, recompute before next word
  logic [1:0]  perm_q, perm_d;
  logic [31:0] speed_q, speed_d;
  logic        out_valid_q, out_valid_d;
  mssbt_pkg::out_word_t out_word_q, out_word_d;

  logic       in_acc;
  logic       out_free;
  logic       lane_start;
  logic       map_start;
  logic       map_done;
  logic [31:0] map_speed;
  logic       braking;
  logic [1:0] perm_new;
  mssbt_pkg::lane_stat_t lane_min, lane_max;

  assign in_stall_o = !((state_q == mssbt_pkg::CS_IDLE) && !dirty_q);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign lane_start = (state_q == mssbt_pkg::CS_IDLE) && dirty_q;

  // permission comes from the brake flag held since the previous tick
  always_comb begin
    priority if (braking) begin
      perm_new = mssbt_pkg::PERM_BRAKE;
    end else if (((in_word_i.tempo == mssbt_pkg::TEMPO_LO) &&
                  (in_word_i.limit_switch_state == mssbt_pkg::LIMIT_END)) ||
                 !in_word_i.init_done ||
                 (in_word_i.power_state != mssbt_pkg::POWER_GOOD)) begin
      perm_new = mssbt_pkg::PERM_STOP;
    end else begin
      perm_new = mssbt_pkg::PERM_RUN;
    end
  end

  assign map_start = in_acc && (perm_new == mssbt_pkg::PERM_RUN);

  always_comb begin
    state_d     = state_q;
    perm_d      = perm_q;
    speed_d     = speed_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q && out_stall_i;
    dirty_d     = limit_cfg_wr || (dirty_q && !lane_start);
    unique case (state_q)
      mssbt_pkg::CS_IDLE: begin
        if (dirty_q) begin
          state_d = mssbt_pkg::CS_LIMITS;
        end else if (in_acc) begin
          perm_d = perm_new;
          if (perm_new == mssbt_pkg::PERM_RUN) begin
            state_d = mssbt_pkg::CS_MAP;
          end else begin
            speed_d = (perm_new == mssbt_pkg::PERM_BRAKE) ? mssbt_pkg::BRAKE_SPEED : 32'd0;
            state_d = mssbt_pkg::CS_HOLD;
          end
        end
      end
      mssbt_pkg::CS_LIMITS: begin
        if (!lane_min.busy && !lane_max.busy) begin
          state_d = mssbt_pkg::CS_IDLE;
        end
      end
      mssbt_pkg::CS_MAP: begin
        if (map_done) begin
          speed_d = map_speed;
          state_d = mssbt_pkg::CS_HOLD;
        end
      end
      mssbt_pkg::CS_HOLD: begin
        if (out_free) begin
          // brake flag already holds this tick's timer update
          out_word_d.move_permission = perm_q;
          out_word_d.drive_enable    = (perm_q != mssbt_pkg::PERM_STOP);
          out_word_d.speed_command   = speed_q;
          out_word_d.brake_active    = braking;
          out_valid_d                = 1'b1;
          state_d                    = mssbt_pkg::CS_IDLE;
        end
      end
      default: state_d = mssbt_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mssbt_pkg::CS_IDLE;
      dirty_q     <= 1'b0;          // reset limits are already correct (zero)
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dirty_q     <= dirty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    perm_q     <= perm_d;
    speed_q    <= speed_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // ---------------------------------------------------------------------
  // Datapath units
  // ---------------------------------------------------------------------
  mssbt_limit u_lim_min (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .base_i  (min_speed_q),
    .ratio_i (ratio_q),
    .scale_i (scale_q),
    .stat_o  (lane_min)
  );

  mssbt_limit u_lim_max (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .base_i  (max_speed_q),
    .ratio_i (ratio_q),
    .scale_i (scale_q),
    .stat_o  (lane_max)
  );

  mssbt_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (map_start),
    .tempo_i (in_word_i.tempo),
    .lo_i    (lane_min.limit),
    .hi_i    (lane_max.limit),
    .done_o  (map_done),
    .speed_o (map_speed)
  );

  mssbt_brake u_brake (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_i           (in_acc),
    .now_i            (in_word_i.now_ms),
    .vel_i            (in_word_i.measured_velocity),
    .brake_velocity_i (brake_vel_q),
    .brake_delay_i    (brake_delay_q),
    .braking_o        (braking)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
`ifndef SYNTHESIS
  // a word must never see limits that are still being recomputed
  a_no_accept_during_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!lane_min.busy && !lane_max.busy))
    else $error("word accepted while speed limit lanes busy");

  // a run word goes straight into the tempo map
  a_run_enters_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_start |=> (state_q == mssbt_pkg::CS_MAP))
    else $error("run word did not enter map state");

  // map finishes only for a word the controller is waiting on
  a_map_done_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_done |-> (state_q == mssbt_pkg::CS_MAP))
    else $error("map unit finished outside map state");

  // a limit write is never lost: stale flag follows the write
  a_cfg_marks_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_cfg_wr |=> dirty_q)
    else $error("limit register write did not mark limits stale");
`endif

endmodule

`default_nettype wire

FILE: test/tb_motor_speed_supervisor_brake_timer_core.sv
// Testbench for the motor speed supervisor and overspeed brake timer core.
`timescale 1ns / 100ps

module tb_motor_speed_supervisor_brake_timer_core;
  import mssbt_pkg::*;

  // Cycles let pass before each register write: covers the limit recompute
  // and any tick still in the datapath.
  localparam int unsigned SETTLE_CYCLES = 80;
  // Long output hold-off used once to back the block up into its input.
  localparam int unsigned HOLD_CYCLES   = 300;
  // Drain time at the end of the run, a bit over the slowest tick.
  localparam int unsigned DRAIN_CYCLES  = 60;
  // Hard stop, several times over the slowest correct run.
  localparam int unsigned TIMEOUT_NS    = 6_000_000;

  // Predicts one output word per accepted tick and checks the block's words
  // against those predictions in order.
  class supervisor_ledger;
    logic [15:0] min_speed;
    logic [15:0] max_speed;
    logic [15:0] ratio_pct;
    logic [15:0] vel_scale;
    logic [22:0] brake_vel;
    logic [31:0] brake_delay;
    bit          braking;
    logic [31:0] brake_start;
    logic [31:0] last_slow;
    out_word_t   pending_cmds[$];
    int unsigned errors;

    function new();
      min_speed   = '0;
      max_speed   = '0;
      ratio_pct   = 16'd100;
      vel_scale   = 16'd1;
      brake_vel   = '0;
      brake_delay = '0;
      braking     = 1'b0;
      brake_start = '0;
      last_slow   = '0;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MIN_TEMPO_SPEED:    min_speed   = data[15:0];
        CFG_MAX_TEMPO_SPEED:    max_speed   = data[15:0];
        CFG_GEAR_RATIO_PERCENT: ratio_pct   = data[15:0];
        CFG_VELOCITY_SCALE:     vel_scale   = data[15:0];
        CFG_BRAKE_VELOCITY:     brake_vel   = data[22:0];
        CFG_BRAKE_DELAY_MS:     brake_delay = data[31:0];
        default: ;
      endcase
    endfunction

    // base * ratio at full width, / 100, truncate, * scale, truncate
    function logic [15:0] scaled_limit(logic [15:0] base);
      logic [63:0] acc;
      acc = {48'd0, base} * {48'd0, ratio_pct};
      acc = acc / PERCENT;
      acc = {48'd0, acc[15:0]} * {48'd0, vel_scale};
      return acc[15:0];
    endfunction

    function void note_tick(in_word_t w);
      out_word_t          cmd;
      longint             t_rel, t_lo, span, lo, hi, line, mag, thr;
      logic signed [23:0] vel;
      logic [31:0]        since;
      cmd = '0;

      // permission uses the brake flag left by the previous tick
      if (braking)
        cmd.move_permission = PERM_BRAKE;
      else if ((w.tempo == TEMPO_LO && w.limit_switch_state == LIMIT_END) ||
               !w.init_done || w.power_state != POWER_GOOD)
        cmd.move_permission = PERM_STOP;
      else
        cmd.move_permission = PERM_RUN;

      case (cmd.move_permission)
        PERM_RUN: begin
          // signed 64-bit line through (32, lo) and (144, hi), truncating division
          lo    = longint'(scaled_limit(min_speed));
          hi    = longint'(scaled_limit(max_speed));
          t_rel = longint'(w.tempo);
          t_lo  = longint'(TEMPO_LO);
          span  = longint'(TEMPO_SPAN);
          line  = (t_rel - t_lo) * (hi - lo) / span + lo;
          cmd.speed_command = line[31:0];
        end
        PERM_BRAKE: cmd.speed_command = BRAKE_SPEED;
        default:    cmd.speed_command = '0;
      endcase
      cmd.drive_enable = (cmd.move_permission != PERM_STOP);

      // overspeed timer, all time differences modulo 2^32
      vel = w.measured_velocity;
      mag = longint'(vel);
      if (mag < 0) mag = -mag;
      thr = longint'(brake_vel);
      if (mag < thr) last_slow = w.now_ms;
      since = w.now_ms - last_slow;
      if (since > brake_delay && !braking) begin
        brake_start = w.now_ms;
        braking     = 1'b1;
      end
      since = w.now_ms - brake_start;
      if (braking && since > BRAKE_HOLD_MS) begin
        brake_start = '0;
        braking     = 1'b0;
      end
      cmd.brake_active = braking;
      pending_cmds.push_back(cmd);
    endfunction

    task log_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (errors < 40)
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      if (pending_cmds.size() == 0) begin
        log_mismatch("word with nothing expected", got.speed_command, '0);
        return;
      end
      want = pending_cmds.pop_front();
      if (got.move_permission !== want.move_permission)
        log_mismatch("move_permission", 32'(got.move_permission),
                     32'(want.move_permission));
      if (got.drive_enable !== want.drive_enable)
        log_mismatch("drive_enable", 32'(got.drive_enable), 32'(want.drive_enable));
      if (got.speed_command !== want.speed_command)
        log_mismatch("speed_command", got.speed_command, want.speed_command);
      if (got.brake_active !== want.brake_active)
        log_mismatch("brake_active", 32'(got.brake_active), 32'(want.brake_active));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  supervisor_ledger ledger;
  bit               hold_req    = 1'b0;  // ask the receiver for one long hold-off
  bit               steady_tail = 1'b0;  // last part of the run: no idling at all
  bit               fast_mode   = 1'b0;  // current velocity regime of the random ticks
  logic [31:0]      clock_ms    = '0;    // running millisecond time of the random ticks

  motor_speed_supervisor_brake_timer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // Both handshakes sampled on the same edge, before this edge's updates land.
  // Output first: a word leaving now always belongs to an earlier tick.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) ledger.check_word(out_word);
      if (in_valid && !in_stall) ledger.note_tick(in_word);
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the tail.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (steady_tail) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  // One register write; the pause ahead of it lets the block go idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.set_reg(idx, data);
  endtask

  task automatic apply_settings(logic [15:0] min_spd, logic [15:0] max_spd,
                                logic [15:0] ratio, logic [15:0] scale,
                                logic [22:0] brake_v, logic [31:0] delay_ms);
    while (ledger.pending_cmds.size() != 0) @(posedge clk);
    write_reg(CFG_MIN_TEMPO_SPEED,    {16'd0, min_spd});
    write_reg(CFG_MAX_TEMPO_SPEED,    {16'd0, max_spd});
    write_reg(CFG_GEAR_RATIO_PERCENT, {16'd0, ratio});
    write_reg(CFG_VELOCITY_SCALE,     {16'd0, scale});
    write_reg(CFG_BRAKE_VELOCITY,     {9'd0, brake_v});
    write_reg(CFG_BRAKE_DELAY_MS,     delay_ms);
  endtask

  // Offer one tick word, hold it until taken, then maybe idle for a burst.
  task automatic tick(logic [31:0] now_ms, logic [7:0] tempo, logic [1:0] lim,
                      logic init, logic [2:0] pwr, logic signed [23:0] vel);
    in_word_t w;
    w.now_ms             = now_ms;
    w.tempo              = tempo;
    w.limit_switch_state = lim;
    w.init_done          = init;
    w.power_state        = pwr;
    w.measured_velocity  = vel;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    if (!steady_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Velocity on the chosen side of the brake threshold, sometimes pure noise.
  function automatic logic signed [23:0] pick_velocity(logic [22:0] thr, bit fast);
    int unsigned mag;
    logic [31:0] raw;
    if ($urandom_range(0, 19) == 0) begin
      raw = $urandom;
      return raw[23:0];
    end
    if (fast || thr == 0)
      mag = $urandom_range(thr, 23'h7FFFFF);
    else
      mag = $urandom_range(0, thr - 1);
    raw = $urandom_range(0, 1) ? -mag : mag;
    return raw[23:0];
  endfunction

  // Mostly plausible control ticks: time moving forward in small steps with
  // stretches of overspeed long enough to trip the brake; now and then a
  // time jump, an odd tempo or a bad status.
  task automatic random_ticks(int unsigned count);
    logic [7:0] tempo;
    logic [2:0] pwr;
    repeat (count) begin
      clock_ms = clock_ms + $urandom_range(1, 60);
      if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
      if ($urandom_range(0, 14) == 0) fast_mode = !fast_mode;
      case ($urandom_range(0, 9))
        0, 1:    tempo = 8'($urandom_range(0, 255));
        2:       tempo = TEMPO_LO;
        default: tempo = 8'($urandom_range(32, 144));
      endcase
      pwr = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(0, 7)) : POWER_GOOD;
      tick(clock_ms, tempo, 2'($urandom_range(0, 3)), ($urandom_range(0, 9) != 0), pwr,
           pick_velocity(ledger.brake_vel, fast_mode));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    ledger = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: limits 3000 / 9000, threshold 500, brake delay 10 ms.
    apply_settings(16'd1000, 16'd3000, 16'd150, 16'd2, 23'd500, 32'd10);
    tick(32'd0,    TEMPO_LO, LIMIT_END, 1'b1, POWER_GOOD, 24'sd0);    // end switch at tempo 32
    tick(32'd1,    TEMPO_LO, 2'd1,      1'b1, POWER_GOOD, 24'sd0);    // low end of the line
    tick(32'd2,    8'd144,   LIMIT_END, 1'b1, POWER_GOOD, -24'sd1);   // high end, switch ignored
    tick(32'd3,    8'd0,     2'd0,      1'b1, POWER_GOOD, 24'sd499);  // below the line
    tick(32'd4,    8'd255,   2'd3,      1'b1, POWER_GOOD, -24'sd499); // above the line
    tick(32'd5,    8'd100,   2'd1,      1'b0, POWER_GOOD, 24'sd0);    // init not done
    tick(32'd6,    8'd100,   2'd1,      1'b1, 3'd0,       24'sd0);    // power bad
    tick(32'd7,    8'd100,   2'd1,      1'b1, 3'd7,       24'sd0);
    tick(32'd8,    8'd88,    LIMIT_END, 1'b1, POWER_GOOD, 24'sd0);
    // overspeed for more than the delay starts the brake, held 2000 ms
    tick(32'd10,   8'd60,    2'd1,      1'b1, POWER_GOOD, 24'sd0);
    tick(32'd15,   8'd60,    2'd1,      1'b1, POWER_GOOD, 24'sd500);   // at threshold
    tick(32'd21,   8'd60,    2'd1,      1'b1, POWER_GOOD, 24'sh800000); // brake starts
    tick(32'd30,   8'd60,    2'd1,      1'b1, POWER_GOOD, 24'sh7FFFFF);
    tick(32'd2021, 8'd60,    2'd1,      1'b1, POWER_GOOD, 24'sd0);     // exactly 2000: held
    tick(32'd2022, 8'd60,    2'd1,      1'b1, POWER_GOOD, 24'sd0);     // released
    tick(32'd2023, 8'd60,    2'd1,      1'b1, POWER_GOOD, 24'sd0);
    // brake starting at time zero after a wrap of the clock
    tick(32'hFFFF_FFF0, 8'd60, 2'd1,    1'b1, POWER_GOOD, 24'sd0);
    tick(32'd0,    8'd60,    2'd1,      1'b1, POWER_GOOD, 24'sd600);
    tick(32'd5,    8'd60,    2'd1,      1'b1, POWER_GOOD, 24'sd600);
    tick(32'd2001, 8'd60,    2'd1,      1'b1, POWER_GOOD, 24'sd600);   // released
    tick(32'd2002, 8'd60,    2'd1,      1'b1, POWER_GOOD, -24'sd600);  // restarts at once
    tick(32'd2003, TEMPO_LO, LIMIT_END, 1'b0, 3'd5,       24'sd0);     // braking overrides stop
    in_valid <= 1'b0;

    // Nominal settings; the receiver backs off long enough to fill the block.
    apply_settings(16'd1000, 16'd5000, 16'd100, 16'd1, 23'd1000, 32'd20);
    clock_ms = 32'd5000;
    hold_req = 1'b1;
    random_ticks(160);

    // All-ones settings, falling line with a negative wrap, zero brake delay.
    apply_settings(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 23'h7FFFFF, 32'd0);
    random_ticks(160);

    // Zero limits, zero threshold (never slow), brake delay that never expires.
    apply_settings(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 23'd0, 32'hFFFF_FFFF);
    random_ticks(160);

    apply_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   23'($urandom_range(0, 100000)), 32'($urandom_range(0, 300)));
    random_ticks(160);

    steady_tail = 1'b1;
    apply_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 400)), 16'($urandom_range(0, 40)),
                   23'($urandom_range(0, 100000)), 32'($urandom_range(0, 300)));
    random_ticks(160);

    while (ledger.pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/mssbt_pkg.sv
rtl/mssbt_limit.sv
rtl/mssbt_map.sv
rtl/mssbt_brake.sv
rtl/motor_speed_supervisor_brake_timer_core.sv
test/tb_motor_speed_supervisor_brake_timer_core.sv
